>>> hdl/bes_pkg.sv
// ----------------------------------------------------------------------------
// bes_pkg
// Shared types and constants for the bounded element sorter: the link
// record passed between neighboring sort cells and the register map.
// ----------------------------------------------------------------------------
package bes_pkg;

  // Width of one element word.
  localparam int unsigned DATA_W = 32;

  // Width of a size register and its value after reset.
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Width of the result position field.
  localparam int unsigned POS_W = 6;

  // APB data and address widths.
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  // Register indexes, taken from the word address bit.
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // What one cell shows its neighbors: its word, whether it holds one, and
  // whether it holds a word greater than the one being inserted.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     occ;
    logic                     gt;
  } link_t;

endpackage

>>> hdl/bes_cell.sv
// ----------------------------------------------------------------------------
// bes_cell
// One cell of the insertion chain. It holds one word of the sorted row.
// On insert it keeps its word, takes the new word, or takes its left
// neighbor's word; on unload it takes its right neighbor's word.
// ----------------------------------------------------------------------------
module bes_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 insert,
  input  logic                                 drain,
  input  logic signed [bes_pkg::DATA_W-1:0]    new_value,
  input  bes_pkg::link_t                       left,
  input  bes_pkg::link_t                       right,
  output bes_pkg::link_t                       own
);

  logic signed [bes_pkg::DATA_W-1:0] value;
  logic                              occ;
  logic                              gt;

  // An empty cell counts as greater than any word, so the empty tail
  // always lies behind the insertion point.
  assign gt = !occ || (new_value < value);

  assign own.value = value;
  assign own.occ   = occ;
  assign own.gt    = gt;

  // Occupancy is control state and is cleared by reset and by a new size.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      occ <= 1'b0;
    end else if (insert) begin
      if (left.gt) begin
        occ <= left.occ;
      end else if (gt) begin
        occ <= 1'b1;
      end
    end else if (drain) begin
      occ <= right.occ;
    end
  end

  // The stored word follows the same moves as its occupancy bit.
  always_ff @(posedge clk) begin
    if (insert) begin
      if (left.gt) begin
        value <= left.value;
      end else if (gt) begin
        value <= new_value;
      end
    end else if (drain) begin
      value <= right.value;
    end
  end

endmodule

>>> hdl/bounded_element_sorter.sv
// ----------------------------------------------------------------------------
// bounded_element_sorter
// Collects rows x columns signed words and returns them in ascending order.
// ----------------------------------------------------------------------------
// Each word is inserted into a chain of MAX_DIM*MAX_DIM sort cells in the
// cycle it is accepted. When the word that completes rows x columns
// arrives, the chain unloads from its head, one result per cycle in which
// the output is ready, each carrying its position and a last flag on the
// final one; the chain shift sets this rate, and no input word is taken
// until the last result of the run has been taken. Row and column sizes
// above MAX_DIM count as MAX_DIM; a zero size makes the block take and
// drop every word. Writing either size register abandons a partly loaded
// run. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module bounded_element_sorter #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bes_pkg::PADDR_W-1:0]         paddr,
  input  logic [bes_pkg::PDATA_W-1:0]         pwdata,
  output logic [bes_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bes_pkg::DATA_W-1:0]   element_value,
  // Output channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bes_pkg::DATA_W-1:0]   sorted_value,
  output logic [bes_pkg::POS_W-1:0]           position,
  output logic                                last_of_run
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CLAMP_W = (DIM_W > bes_pkg::CFG_W) ? DIM_W : bes_pkg::CFG_W;

  logic [bes_pkg::CFG_W-1:0] row_count;
  logic [bes_pkg::CFG_W-1:0] column_count;
  logic                      cfg_write;
  logic [DIM_W-1:0]          rows_used;
  logic [DIM_W-1:0]          cols_used;
  logic [CNT_W-1:0]          total;
  logic [CNT_W-1:0]          count;
  logic                      draining;
  logic                      in_take;
  logic                      out_take;
  logic                      insert;

  bes_pkg::link_t            links [DEPTH];
  bes_pkg::link_t            head_link;
  bes_pkg::link_t            tail_link;

  // Configuration registers; either write also restarts the run.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= bes_pkg::CFG_RESET;
      column_count <= bes_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        bes_pkg::REG_ROW_COUNT:    row_count    <= pwdata[bes_pkg::CFG_W-1:0];
        bes_pkg::REG_COLUMN_COUNT: column_count <= pwdata[bes_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bes_pkg::REG_ROW_COUNT:
        prdata = bes_pkg::PDATA_W'(row_count);
      bes_pkg::REG_COLUMN_COUNT:
        prdata = bes_pkg::PDATA_W'(column_count);
      default:
        prdata = '0;
    endcase
  end

  // Sizes saturate at MAX_DIM; the product is the run length.
  assign rows_used = (CLAMP_W'(row_count) > CLAMP_W'(MAX_DIM))
                     ? DIM_W'(MAX_DIM) : DIM_W'(row_count);
  assign cols_used = (CLAMP_W'(column_count) > CLAMP_W'(MAX_DIM))
                     ? DIM_W'(MAX_DIM) : DIM_W'(column_count);
  assign total     = CNT_W'(rows_used) * CNT_W'(cols_used);

  // Handshakes. Words are inserted only while the run length is nonzero.
  assign in_ready  = !draining;
  assign in_take   = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;
  assign insert    = in_take && (total != '0);

  // Fill and unload sequencing: the counter counts words loaded, then
  // results delivered.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      count    <= '0;
      draining <= 1'b0;
    end else if (draining) begin
      if (out_take) begin
        if (count == total - CNT_W'(1)) begin
          count    <= '0;
          draining <= 1'b0;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end else if (in_take) begin
      if (total == '0) begin
        count <= '0;
      end else if (count + CNT_W'(1) == total) begin
        count    <= '0;
        draining <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Chain ends: nothing shifts in from the left during insertion, and
  // empty cells enter from the right during unloading.
  assign head_link = '{value: '0, occ: 1'b0, gt: 1'b0};
  assign tail_link = '{value: '0, occ: 1'b0, gt: 1'b1};

  // The chain of sort cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bes_pkg::link_t left_link;
    bes_pkg::link_t right_link;

    if (i == 0) begin : g_head
      assign left_link = head_link;
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_link = tail_link;
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end

    bes_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (cfg_write),
      .insert    (insert),
      .drain     (out_take),
      .new_value (element_value),
      .left      (left_link),
      .right     (right_link),
      .own       (links[i])
    );
  end

  // Results come straight from the head cell.
  assign out_valid    = draining;
  assign sorted_value = links[0].value;
  assign position     = bes_pkg::POS_W'(count);
  assign last_of_run  = (count == total - CNT_W'(1));

  // The head cell holds a word whenever a result is offered.
  a_head_full: assert property (@(posedge clk) disable iff (rst)
    draining |-> links[0].occ)
    else $error("result offered from an empty head cell");

  // The delivery counter stays inside the run.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    draining |-> (count < total))
    else $error("delivery counter beyond the run length");

  // The chain stays in ascending order at its head.
  if (DEPTH > 1) begin : g_order_chk
    a_order: assert property (@(posedge clk) disable iff (rst)
      (draining && links[1].occ) |-> !(links[1].value < links[0].value))
      else $error("chain out of ascending order");
  end

  // Taking the last result ends the run.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_of_run && !cfg_write) |=> (!out_valid && count == '0))
    else $error("run did not end after its last result");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded element sorter. A short table of
// directed words and size writes comes first. Random size settings follow,
// each with a few whole runs of random words and now and then a run cut
// short by the next size write. Every sorted word that comes out is checked
// against a run-sorting model kept in the bench.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM      = 8;
  localparam int unsigned RUN_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned TAIL_CYCLES  = 80;

  localparam logic [bes_pkg::PADDR_W-1:0] ROW_ADDR = {bes_pkg::REG_ROW_COUNT, 2'b00};
  localparam logic [bes_pkg::PADDR_W-1:0] COL_ADDR = {bes_pkg::REG_COLUMN_COUNT, 2'b00};

  // One sorted word as it leaves the block.
  typedef struct packed {
    logic signed [bes_pkg::DATA_W-1:0] value;
    logic [bes_pkg::POS_W-1:0]         pos;
    logic                              last;
  } ranked_word_t;

  typedef enum logic [1:0] {ROW_WRITE, COL_WRITE, WORD_IN} stim_op_t;

  // One row of the directed table. Rows marked typed carry a hand-written
  // result; they are all single-word runs.
  typedef struct packed {
    stim_op_t      op;
    logic [31:0]   data;
    logic          typed;
    ranked_word_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bes_pkg::PADDR_W-1:0] paddr = '0;
  logic [bes_pkg::PDATA_W-1:0] pwdata = '0;
  logic [bes_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [bes_pkg::DATA_W-1:0] element_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [bes_pkg::DATA_W-1:0] sorted_value;
  logic [bes_pkg::POS_W-1:0] position;
  logic last_of_run;

  bounded_element_sorter uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element_value(element_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .position     (position),
    .last_of_run  (last_of_run)
  );

  // Sorting model state: size registers, words of the open run, sorted run.
  logic [bes_pkg::CFG_W-1:0]         rows_reg = bes_pkg::CFG_RESET;
  logic [bes_pkg::CFG_W-1:0]         cols_reg = bes_pkg::CFG_RESET;
  int unsigned                       fill = 0;
  logic signed [bes_pkg::DATA_W-1:0] run_words [RUN_DEPTH];
  logic signed [bes_pkg::DATA_W-1:0] ranked [RUN_DEPTH];
  ranked_word_t                      sorted_due [$];

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned runs_done = 0;
  int unsigned runs_cut = 0;
  int unsigned size_writes = 0;
  int unsigned burst_left = 0;
  stim_row_t   directed_rows [25];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("%0t MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned size_of(input logic [bes_pkg::CFG_W-1:0] dim);
    return (dim > MAX_DIM) ? MAX_DIM : int'(dim);
  endfunction

  // Store one word of the run; on the word that completes it, sort the run
  // into ranked[] and return its length, else return zero.
  function automatic int unsigned absorb_element(
    input logic signed [bes_pkg::DATA_W-1:0] word);
    int unsigned total;
    int unsigned k;
    logic signed [bes_pkg::DATA_W-1:0] v;
    total = size_of(rows_reg) * size_of(cols_reg);
    if (total == 0) begin
      fill = 0;
      return 0;
    end
    if (fill >= total) fill = 0;
    run_words[fill] = word;
    fill++;
    if (fill < total) return 0;
    // Insertion sort, ascending in signed order.
    for (int unsigned i = 0; i < total; i++) begin
      v = run_words[i];
      k = i;
      while (k > 0 && v < ranked[k-1]) begin
        ranked[k] = ranked[k-1];
        k--;
      end
      ranked[k] = v;
    end
    fill = 0;
    runs_done++;
    return total;
  endfunction

  // Offer one word and hold it until taken, then log what it should produce.
  // Called at a rising edge; valid stays high for a back-to-back word.
  task automatic send_word(input logic signed [bes_pkg::DATA_W-1:0] word,
                           input logic typed, input ranked_word_t want);
    int unsigned n;
    in_valid <= 1'b1;
    element_value <= word;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
    n = absorb_element(word);
    if (typed) begin
      sorted_due.push_back(want);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        sorted_due.push_back(ranked_word_t'{ranked[i], bes_pkg::POS_W'(i), (i + 1 == n)});
      end
    end
  endtask

  // Let every due sorted word come out, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup and access cycles of one size register write.
  task automatic write_size(input logic [bes_pkg::PADDR_W-1:0] addr,
                            input logic [bes_pkg::PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == bes_pkg::REG_ROW_COUNT) rows_reg = data[bes_pkg::CFG_W-1:0];
    else cols_reg = data[bes_pkg::CFG_W-1:0];
    fill = 0;
    size_writes++;
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    burst_left--;
  endtask

  // Size choice with the extremes well represented; above eight saturates.
  function automatic logic [bes_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 15))
      0:       return '0;
      1, 2:    return bes_pkg::CFG_W'(1);
      3:       return bes_pkg::CFG_W'(8);
      4:       return bes_pkg::CFG_W'($urandom_range(9, 15));
      default: return bes_pkg::CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Element mix: extremes, a narrow band that forces ties, and full range.
  function automatic logic signed [bes_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return bes_pkg::DATA_W'(int'($urandom_range(0, 15)) - 8);
      default: return bes_pkg::DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [bes_pkg::PDATA_W-1:0] size_word(
    input logic [bes_pkg::CFG_W-1:0] dim);
    return ($urandom() & 32'hFFFF_FFF0) | bes_pkg::PDATA_W'(dim);
  endfunction

  // Receiver stalls: each mode is drawn at random, from always ready through
  // random and masked patterns.
  always @(posedge clk) begin : receiver_stalls
    static int unsigned tick = 0;
    static int unsigned mode = 0;
    static logic [7:0] mask = 8'hFF;
    if (tick % 160 == 0) begin
      mode = $urandom_range(0, 3);
      mask = 8'($urandom());
    end
    case (mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= mask[tick % 8];
      default: out_ready <= ($urandom_range(0, 5) != 0);
    endcase
    tick++;
  end

  // Compare every accepted sorted word with the oldest one due.
  always @(posedge clk) begin : check_results
    ranked_word_t head;
    if (!rst && out_valid && out_ready) begin
      if (sorted_due.size() == 0) begin
        flag_error($sformatf("unexpected word value %0d position %0d last %0b",
                             sorted_value, position, last_of_run));
      end else begin
        head = sorted_due.pop_front();
        results_checked++;
        if (sorted_value !== head.value)
          flag_error($sformatf("sorted_value %0d, wanted %0d at position %0d",
                               sorted_value, head.value, head.pos));
        if (position !== head.pos)
          flag_error($sformatf("position %0d, wanted %0d", position, head.pos));
        if (last_of_run !== head.last)
          flag_error($sformatf("last_of_run %0b, wanted %0b at position %0d",
                               last_of_run, head.last, head.pos));
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("[bounded_element_sorter] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_words;
    int unsigned total;
    int unsigned runs;
    int unsigned count;

    // Directed table. The first three words open an 8x8 run that the row
    // write abandons; then single-word runs with the extremes, a 1x2 run,
    // dropped words at zero size, and a 1x8 run with saturated columns and
    // repeated values.
    directed_rows = '{
      '{WORD_IN,   32'h0000_0011, 1'b0, '0},
      '{WORD_IN,   32'hFFFF_FFEE, 1'b0, '0},
      '{WORD_IN,   32'h1234_5678, 1'b0, '0},
      '{ROW_WRITE, 32'hFFFF_FFF1, 1'b0, '0},
      '{COL_WRITE, 32'h0000_0001, 1'b0, '0},
      '{WORD_IN,   32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 6'd0, 1'b1}},
      '{WORD_IN,   32'h8000_0000, 1'b1, '{32'h8000_0000, 6'd0, 1'b1}},
      '{WORD_IN,   32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b1}},
      '{WORD_IN,   32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 6'd0, 1'b1}},
      '{COL_WRITE, 32'h0000_0002, 1'b0, '0},
      '{WORD_IN,   32'h0000_0005, 1'b0, '0},
      '{WORD_IN,   32'hFFFF_FFFB, 1'b0, '0},
      '{ROW_WRITE, 32'hA5A5_A5A0, 1'b0, '0},
      '{WORD_IN,   32'hDEAD_BEEF, 1'b0, '0},
      '{WORD_IN,   32'h0BAD_F00D, 1'b0, '0},
      '{ROW_WRITE, 32'h0000_0001, 1'b0, '0},
      '{COL_WRITE, 32'h5A5A_5A5F, 1'b0, '0},
      '{WORD_IN,   32'h0000_0003, 1'b0, '0},
      '{WORD_IN,   32'h8000_0000, 1'b0, '0},
      '{WORD_IN,   32'h0000_0003, 1'b0, '0},
      '{WORD_IN,   32'h7FFF_FFFF, 1'b0, '0},
      '{WORD_IN,   32'hFFFF_FFFF, 1'b0, '0},
      '{WORD_IN,   32'h0000_0000, 1'b0, '0},
      '{WORD_IN,   32'h0000_0003, 1'b0, '0},
      '{WORD_IN,   32'h8000_0000, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_WRITE: begin
          drain_results();
          write_size(ROW_ADDR, directed_rows[i].data);
        end
        COL_WRITE: begin
          drain_results();
          write_size(COL_ADDR, directed_rows[i].data);
        end
        default: begin
          send_word(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
        end
      endcase
    end

    // Random phases: new sizes, then whole runs of random words, the last
    // one sometimes cut short so that the next size write abandons it.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      drain_results();
      case ($urandom_range(0, 3))
        0: begin
          write_size(COL_ADDR, size_word(pick_size()));
          write_size(ROW_ADDR, size_word(pick_size()));
        end
        1: write_size(ROW_ADDR, size_word(pick_size()));
        2: write_size(COL_ADDR, size_word(pick_size()));
        default: begin
          write_size(ROW_ADDR, size_word(pick_size()));
          write_size(COL_ADDR, size_word(pick_size()));
        end
      endcase
      total = size_of(rows_reg) * size_of(cols_reg);
      if (total == 0) begin
        // Zero size: the block takes and drops these.
        repeat ($urandom_range(1, 6)) begin
          pace();
          send_word(pick_value(), 1'b0, '0);
        end
      end else begin
        runs = (total > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
        for (int unsigned r = 0; r < runs; r++) begin
          count = total;
          if (r + 1 == runs && $urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, total);
            if (count < total) runs_cut++;
          end
          // Now and then hold off until every due word has come out.
          if ($urandom_range(0, 4) == 0) drain_results();
          repeat (count) begin
            pace();
            send_word(pick_value(), 1'b0, '0);
            random_words++;
          end
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sorted_due.size() != 0)
      flag_error($sformatf("%0d sorted words never came out", sorted_due.size()));

    $display("Sent %0d words under %0d size writes: %0d runs sorted, %0d cut short.",
             words_sent, size_writes, runs_done, runs_cut);
    $display("Checked %0d sorted words with %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("[bounded_element_sorter] OK");
    end else begin
      $display("[bounded_element_sorter] ERROR");
    end
    $finish;
  end

endmodule
